>>> hdl/tgf_pkg.sv
package tgf_pkg;

   localparam int COMMAND_W = 2;
   localparam int ELEMENT_W = 10;
   localparam int GROUP_W   = 4;
   localparam int STATUS_W  = 2;

   localparam logic [COMMAND_W-1:0] CMD_ASSIGN  = 2'd0;
   localparam logic [COMMAND_W-1:0] CMD_ENQUEUE = 2'd1;
   localparam logic [COMMAND_W-1:0] CMD_DEQUEUE = 2'd2;
   localparam logic [COMMAND_W-1:0] CMD_CLEAR   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef logic [3:0] step_type;

   localparam step_type STEP_NONE      = 4'd0;
   localparam step_type STEP_INIT      = 4'd1;
   localparam step_type STEP_WIPE      = 4'd2;
   localparam step_type STEP_ASSIGN    = 4'd3;
   localparam step_type STEP_ENQ_TEAM  = 4'd4;
   localparam step_type STEP_ENQ_WRITE = 4'd5;
   localparam step_type STEP_DEQ_TEAM  = 4'd6;
   localparam step_type STEP_DEQ_SLOT  = 4'd7;
   localparam step_type STEP_DEQ_WRITE = 4'd8;
   localparam step_type STEP_FULL      = 4'd9;
   localparam step_type STEP_EMPTY     = 4'd10;

   typedef struct packed {
      logic     load_req;
      step_type step;
      logic     load_rsp;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic sweep_last;
   } stat_type;

endpackage

>>> hdl/team_grouped_fifo.sv
// request to response valid: the controller steps through ASG (assign), FULL (full
// enqueue), EMPTY (empty dequeue), ENQ_A to ENQ_C (enqueue), DEQ_A to DEQ_D (dequeue)
// or WIPE over the team table (clear), then FIN; set by the registered memory reads in
// sequence; the controller serves one transaction at a time
// reset: synchronous; afterwards the membership and team tables are swept over
// max(ELEMENT_COUNT, TEAM_COUNT) addresses with req_stall high
module team_grouped_fifo #(
   parameter int ELEMENT_COUNT = 1024,
   parameter int TEAM_COUNT    = 16,
   parameter int CAPACITY      = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tgf_pkg::COMMAND_W-1:0]        req_command,
   input  logic [tgf_pkg::ELEMENT_W-1:0]        req_element,
   input  logic [tgf_pkg::GROUP_W-1:0]          req_group,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tgf_pkg::STATUS_W-1:0]         rsp_status,
   output logic [tgf_pkg::ELEMENT_W-1:0]        rsp_out_element,
   output logic                                 rsp_has_element
);
   import tgf_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   tgf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .stat        (stat)
   );

   tgf_datapath #(
      .ELEMENT_COUNT (ELEMENT_COUNT),
      .TEAM_COUNT    (TEAM_COUNT),
      .CAPACITY      (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_element     (req_element),
      .req_group       (req_group),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_out_element (rsp_out_element),
      .rsp_has_element (rsp_has_element)
   );

endmodule

>>> hdl/tgf_ctrl.sv
module tgf_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tgf_pkg::COMMAND_W-1:0]        req_command,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tgf_pkg::cmd_type                     cmd,
   input  tgf_pkg::stat_type                    stat
);
   import tgf_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_ASG   = 4'd2;
   localparam logic [3:0] S_ENQ_A = 4'd3;
   localparam logic [3:0] S_ENQ_B = 4'd4;
   localparam logic [3:0] S_ENQ_C = 4'd5;
   localparam logic [3:0] S_DEQ_A = 4'd6;
   localparam logic [3:0] S_DEQ_B = 4'd7;
   localparam logic [3:0] S_DEQ_C = 4'd8;
   localparam logic [3:0] S_DEQ_D = 4'd9;
   localparam logic [3:0] S_WIPE  = 4'd10;
   localparam logic [3:0] S_FULL  = 4'd11;
   localparam logic [3:0] S_EMPTY = 4'd12;
   localparam logic [3:0] S_FIN   = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '{load_req: 1'b0, step: STEP_NONE, load_rsp: 1'b0};
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               unique case (req_command)
                  CMD_ASSIGN:  state_in = S_ASG;
                  CMD_ENQUEUE: state_in = stat.full ? S_FULL : S_ENQ_A;
                  CMD_DEQUEUE: state_in = stat.empty ? S_EMPTY : S_DEQ_A;
                  CMD_CLEAR:   state_in = S_WIPE;
               endcase
            end
         end
         S_INIT: begin
            cmd.step = STEP_INIT;
            if (stat.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_ASG: begin
            cmd.step = STEP_ASSIGN;
            state_in = S_FIN;
         end
         S_ENQ_A: state_in = S_ENQ_B;
         S_ENQ_B: begin
            cmd.step = STEP_ENQ_TEAM;
            state_in = S_ENQ_C;
         end
         S_ENQ_C: begin
            cmd.step = STEP_ENQ_WRITE;
            state_in = S_FIN;
         end
         S_DEQ_A: state_in = S_DEQ_B;
         S_DEQ_B: begin
            cmd.step = STEP_DEQ_TEAM;
            state_in = S_DEQ_C;
         end
         S_DEQ_C: begin
            cmd.step = STEP_DEQ_SLOT;
            state_in = S_DEQ_D;
         end
         S_DEQ_D: begin
            cmd.step = STEP_DEQ_WRITE;
            state_in = S_FIN;
         end
         S_WIPE: begin
            cmd.step = STEP_WIPE;
            if (stat.sweep_last) begin
               state_in = S_FIN;
            end
         end
         S_FULL: begin
            cmd.step = STEP_FULL;
            state_in = S_FIN;
         end
         S_EMPTY: begin
            cmd.step = STEP_EMPTY;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/tgf_datapath.sv
module tgf_datapath #(
   parameter int ELEMENT_COUNT = 1024,
   parameter int TEAM_COUNT    = 16,
   parameter int CAPACITY      = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [tgf_pkg::ELEMENT_W-1:0]        req_element,
   input  logic [tgf_pkg::GROUP_W-1:0]          req_group,
   input  tgf_pkg::cmd_type                     cmd,
   output tgf_pkg::stat_type                    stat,
   output logic [tgf_pkg::STATUS_W-1:0]         rsp_status,
   output logic [tgf_pkg::ELEMENT_W-1:0]        rsp_out_element,
   output logic                                 rsp_has_element
);
   import tgf_pkg::*;

   localparam int EW      = $clog2(ELEMENT_COUNT);
   localparam int TW      = $clog2(TEAM_COUNT);
   localparam int SW      = $clog2(CAPACITY);
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int OW      = $clog2(TEAM_COUNT + 1);
   localparam int GW      = 1 + 2 * SW;
   localparam int SWEEP_N = (ELEMENT_COUNT > TEAM_COUNT) ? ELEMENT_COUNT : TEAM_COUNT;
   localparam int NW      = $clog2(SWEEP_N);

   localparam logic [NW-1:0] SWEEP_LAST = NW'(SWEEP_N - 1);
   localparam logic [NW-1:0] TEAM_LAST  = NW'(TEAM_COUNT - 1);
   localparam logic [TW-1:0] TEAM_TOP   = TW'(TEAM_COUNT - 1);
   localparam logic [SW-1:0] SLOT_TOP   = SW'(CAPACITY - 1);
   localparam logic [CW-1:0] CAP_FULL   = CW'(CAPACITY);

   logic [TW-1:0]        member_mem [ELEMENT_COUNT];
   logic [ELEMENT_W-1:0] value_mem  [CAPACITY];
   logic [SW-1:0]        link_mem   [CAPACITY];
   logic [GW-1:0]        group_mem  [TEAM_COUNT];
   logic [TW-1:0]        order_mem  [TEAM_COUNT];

   logic [TW-1:0]        member_q;
   logic [ELEMENT_W-1:0] value_q;
   logic [SW-1:0]        link_q;
   logic [GW-1:0]        group_q;
   logic [TW-1:0]        order_q;

   logic [ELEMENT_W-1:0] elem_ff;
   logic [GROUP_W-1:0]   grp_ff;
   logic [TW-1:0]        team_ff, team_in;
   logic [SW-1:0]        fh_ff, fh_in;
   logic [CW-1:0]        hw_ff, hw_in;
   logic [CW-1:0]        used_ff, used_in;
   logic [TW-1:0]        rd_ff, rd_in;
   logic [TW-1:0]        wr_ff, wr_in;
   logic [OW-1:0]        cnt_ff, cnt_in;
   logic [NW-1:0]        sweep_ff, sweep_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [ELEMENT_W-1:0] res_element_ff, res_element_in;
   logic                 res_has_ff, res_has_in;

   logic                 member_we, value_we, link_we, group_we, order_we;
   logic [EW-1:0]        member_wa;
   logic [TW-1:0]        member_wd;
   logic [SW-1:0]        link_wa, link_wd, link_ra;
   logic [TW-1:0]        group_wa, group_ra;
   logic [GW-1:0]        group_wd;

   logic                 g_act;
   logic [SW-1:0]        g_head, g_tail;
   logic                 elem_ok, grp_ok, fresh;
   logic                 sweep_elem, sweep_team;
   logic [TW-1:0]        enq_team;
   logic [SW-1:0]        fh_next;

   assign g_act      = group_q[GW-1];
   assign g_head     = group_q[2*SW-1:SW];
   assign g_tail     = group_q[SW-1:0];
   assign elem_ok    = 32'(elem_ff) < 32'(ELEMENT_COUNT);
   assign grp_ok     = 32'(grp_ff) < 32'(TEAM_COUNT);
   assign sweep_elem = 32'(sweep_ff) < 32'(ELEMENT_COUNT);
   assign sweep_team = 32'(sweep_ff) < 32'(TEAM_COUNT);
   assign enq_team   = elem_ok ? member_q : '0;
   assign fresh      = CW'(fh_ff) >= hw_ff;
   assign fh_next    = fresh ? ((fh_ff == SLOT_TOP) ? '0 : fh_ff + 1'b1) : link_q;

   assign link_ra  = (cmd.step == STEP_DEQ_SLOT) ? g_head : fh_ff;
   assign group_ra = (cmd.step == STEP_ENQ_TEAM) ? enq_team :
                     (cmd.step == STEP_DEQ_TEAM) ? order_q : team_ff;

   assign stat.full       = (used_ff == CAP_FULL);
   assign stat.empty      = (cnt_ff == '0);
   assign stat.sweep_last = (cmd.step == STEP_INIT) ? (sweep_ff == SWEEP_LAST) :
                                                      (sweep_ff == TEAM_LAST);

   always_comb begin
      member_we      = 1'b0;
      member_wa      = EW'(elem_ff);
      member_wd      = TW'(grp_ff);
      value_we       = 1'b0;
      link_we        = 1'b0;
      link_wa        = g_head;
      link_wd        = fh_ff;
      group_we       = 1'b0;
      group_wa       = team_ff;
      group_wd       = group_q;
      order_we       = 1'b0;
      team_in        = team_ff;
      fh_in          = fh_ff;
      hw_in          = hw_ff;
      used_in        = used_ff;
      rd_in          = rd_ff;
      wr_in          = wr_ff;
      cnt_in         = cnt_ff;
      res_status_in  = res_status_ff;
      res_element_in = res_element_ff;
      res_has_in     = res_has_ff;
      sweep_in       = '0;
      unique case (cmd.step)
         STEP_INIT: begin
            sweep_in  = sweep_ff + 1'b1;
            member_we = sweep_elem;
            member_wa = EW'(sweep_ff);
            member_wd = '0;
            group_we  = sweep_team;
            group_wa  = TW'(sweep_ff);
            group_wd  = '0;
         end
         STEP_WIPE: begin
            sweep_in       = sweep_ff + 1'b1;
            group_we       = sweep_team;
            group_wa       = TW'(sweep_ff);
            group_wd       = '0;
            fh_in          = '0;
            hw_in          = '0;
            used_in        = '0;
            rd_in          = '0;
            wr_in          = '0;
            cnt_in         = '0;
            res_status_in  = STATUS_OK;
            res_element_in = '0;
            res_has_in     = 1'b0;
         end
         STEP_ASSIGN: begin
            member_we      = elem_ok && grp_ok;
            res_status_in  = STATUS_OK;
            res_element_in = '0;
            res_has_in     = 1'b0;
         end
         STEP_ENQ_TEAM: team_in = enq_team;
         STEP_ENQ_WRITE: begin
            value_we = 1'b1;
            fh_in    = fh_next;
            hw_in    = fresh ? hw_ff + 1'b1 : hw_ff;
            used_in  = used_ff + 1'b1;
            group_we = 1'b1;
            if (g_act) begin
               link_we  = 1'b1;
               link_wa  = g_tail;
               group_wd = {1'b1, g_head, fh_ff};
            end else begin
               group_wd = {1'b1, fh_ff, fh_ff};
               order_we = 1'b1;
               wr_in    = (wr_ff == TEAM_TOP) ? '0 : wr_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
            end
            res_status_in  = STATUS_OK;
            res_element_in = '0;
            res_has_in     = 1'b0;
         end
         STEP_DEQ_TEAM: team_in = order_q;
         STEP_DEQ_SLOT: ;
         STEP_DEQ_WRITE: begin
            group_we = 1'b1;
            if (g_head == g_tail) begin
               group_wd = {1'b0, g_head, g_tail};
               rd_in    = (rd_ff == TEAM_TOP) ? '0 : rd_ff + 1'b1;
               cnt_in   = cnt_ff - 1'b1;
            end else begin
               group_wd = {1'b1, link_q, g_tail};
            end
            link_we        = 1'b1;
            fh_in          = g_head;
            used_in        = used_ff - 1'b1;
            res_status_in  = STATUS_OK;
            res_element_in = value_q;
            res_has_in     = 1'b1;
         end
         STEP_FULL: begin
            res_status_in  = STATUS_FULL;
            res_element_in = '0;
            res_has_in     = 1'b0;
         end
         STEP_EMPTY: begin
            res_status_in  = STATUS_EMPTY;
            res_element_in = '0;
            res_has_in     = 1'b0;
         end
         default: ;
      endcase
   end

   // storage arrays with registered reads
   always_ff @(posedge clock) begin
      if (member_we) begin
         member_mem[member_wa] <= member_wd;
      end
      member_q <= member_mem[EW'(elem_ff)];
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[fh_ff] <= elem_ff;
      end
      value_q <= value_mem[g_head];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_q <= link_mem[link_ra];
   end

   always_ff @(posedge clock) begin
      if (group_we) begin
         group_mem[group_wa] <= group_wd;
      end
      group_q <= group_mem[group_ra];
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[wr_ff] <= team_ff;
      end
      order_q <= order_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fh_ff    <= '0;
         hw_ff    <= '0;
         used_ff  <= '0;
         rd_ff    <= '0;
         wr_ff    <= '0;
         cnt_ff   <= '0;
         sweep_ff <= '0;
      end else begin
         fh_ff    <= fh_in;
         hw_ff    <= hw_in;
         used_ff  <= used_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         cnt_ff   <= cnt_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         elem_ff <= req_element;
         grp_ff  <= req_group;
      end
      team_ff        <= team_in;
      res_status_ff  <= res_status_in;
      res_element_ff <= res_element_in;
      res_has_ff     <= res_has_in;
      if (cmd.load_rsp) begin
         rsp_status      <= res_status_ff;
         rsp_out_element <= res_element_ff;
         rsp_has_element <= res_has_ff;
      end
   end

endmodule
